@@ rtl/core/tce_pkg.sv @@
// Shared constants, types and helper functions of the turtle command engine.
// Used by tce_ctrl, tce_dp and turtle_command_engine_core; no dependencies.
`default_nettype none

package tce_pkg;

   // Sizing
   localparam int STACK_DEPTH    = 16;
   localparam int TRIG_FRAC_BITS = 16;
   localparam int PTR_W          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W          = $clog2(STACK_DEPTH + 1);

   localparam int KIND_W = 3;
   localparam int AMT_W  = 32;
   localparam int POS_W  = 32;
   localparam int HEAD_W = 25;
   localparam int REM_W  = 23;   // remainder within a quarter turn
   localparam int D_W    = POS_W + 2;

   // Command codes
   localparam logic [KIND_W-1:0] KIND_FWD     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_BACK    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_LEFT    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RIGHT   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_PEN_UP  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_PEN_DN  = 3'd5;
   localparam logic [KIND_W-1:0] KIND_SAVE    = 3'd6;
   localparam logic [KIND_W-1:0] KIND_RESTORE = 3'd7;

   // Angle constants, degrees Q16.16
   localparam logic [HEAD_W-1:0] FULL_TURN    = 25'd23592960;
   localparam logic [HEAD_W-1:0] QUARTER_TURN = 25'd5898240;
   localparam logic [HEAD_W-1:0] HALF_TURN    = 25'd11796480;
   localparam logic [HEAD_W-1:0] THREE_QUARTER_TURN = 25'd17694720;
   localparam logic [26:0]       DEG_TO_RAD   = 27'd74961321;   // pi/180 in Q32
   localparam logic [31:0]       Q30_ONE      = 32'h4000_0000;

   // Shared multiplier
   localparam int MUL_W  = 34;
   localparam int PROD_W = 2 * MUL_W;

   // Trig values
   localparam int TMAG_W     = TRIG_FRAC_BITS + 1;
   localparam int TRIG_W     = TRIG_FRAC_BITS + 2;
   localparam int TRIG_SH    = 30 - TRIG_FRAC_BITS;
   localparam int TRIG_HALF  = (1 << TRIG_SH) >> 1;
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (TRIG_FRAC_BITS - 1);

   // Series evaluation: five sine steps, then six cosine steps
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] SIN_LAST = 4'd4;
   localparam logic [STEP_W-1:0] COS_LAST = 4'd10;
   localparam logic [7:0] HORNER_K [0:10] = '{
      8'd110, 8'd72, 8'd42, 8'd20, 8'd6,
      8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
   localparam logic [31:0] HORNER_RECIP [0:10] = '{
      32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd72),
      32'((64'd1 << 32) / 64'd42),  32'((64'd1 << 32) / 64'd20),
      32'((64'd1 << 32) / 64'd6),   32'((64'd1 << 32) / 64'd132),
      32'((64'd1 << 32) / 64'd90),  32'((64'd1 << 32) / 64'd56),
      32'((64'd1 << 32) / 64'd30),  32'((64'd1 << 32) / 64'd12),
      32'((64'd1 << 32) / 64'd2)};

   // Heading reduction: bias to non-negative, then reciprocal multiply
   localparam int              TURN_SH    = 55;
   localparam logic [31:0]     TURN_RECIP = 32'((64'd1 << TURN_SH) / 64'd23592960);
   localparam logic [MUL_W-1:0] TURN_BIAS = 34'd2170552320;   // 92 full turns

   // Controller to datapath operations
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
   localparam logic [OP_W-1:0] OP_ACCEPT = 4'd1;
   localparam logic [OP_W-1:0] OP_DISP   = 4'd2;
   localparam logic [OP_W-1:0] OP_TURN   = 4'd3;
   localparam logic [OP_W-1:0] OP_SQ     = 4'd4;
   localparam logic [OP_W-1:0] OP_X2     = 4'd5;
   localparam logic [OP_W-1:0] OP_HA     = 4'd6;
   localparam logic [OP_W-1:0] OP_HB     = 4'd7;
   localparam logic [OP_W-1:0] OP_HC     = 4'd8;
   localparam logic [OP_W-1:0] OP_SF     = 4'd9;
   localparam logic [OP_W-1:0] OP_SG     = 4'd10;
   localparam logic [OP_W-1:0] OP_CF     = 4'd11;
   localparam logic [OP_W-1:0] OP_MX     = 4'd12;
   localparam logic [OP_W-1:0] OP_MY     = 4'd13;
   localparam logic [OP_W-1:0] OP_MZ     = 4'd14;
   localparam logic [OP_W-1:0] OP_RSP    = 4'd15;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [STEP_W-1:0] step;
   } tce_cmd_type;

   typedef struct packed {
      logic is_move;
      logic is_turn;
   } tce_stat_type;

   typedef struct packed {
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic [HEAD_W-1:0] head;
      logic              pen;
   } tce_entry_type;

   // Clamp a Q30 value to [0, 1] and round half up to the trig precision
   function automatic logic [TMAG_W-1:0] to_trig(input logic signed [31:0] v);
      logic [30:0] c;
      logic [31:0] s;
      if (v < 0) begin
         c = '0;
      end else if (v > $signed(Q30_ONE)) begin
         c = Q30_ONE[30:0];
      end else begin
         c = v[30:0];
      end
      s = {1'b0, c} + 32'(TRIG_HALF);
      return TMAG_W'(s >> TRIG_SH);
   endfunction

   // Drop the trig fraction bits, rounding half away from zero
   function automatic logic signed [D_W-1:0] scale_round(input logic signed [PROD_W-1:0] p);
      logic [PROD_W-1:0] mag;
      logic              neg;
      neg = p[PROD_W-1];
      mag = neg ? PROD_W'(-p) : PROD_W'(p);
      mag = (mag + ROUND_HALF) >> TRIG_FRAC_BITS;
      return neg ? -$signed(D_W'(mag)) : $signed(D_W'(mag));
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/turtle_command_engine_core.sv @@
// Turtle command engine top level: tce_ctrl sequencer plus tce_dp datapath.
// Words are handled one at a time: the next word is taken only once the result of
// the last one is loaded, and loading waits while the receiver stalls a full result register.
// A move runs eleven series steps, each through states HA, HB and HC, on the one
// shared 34x34 multiplier.
// Reset: synchronous; position 0, heading 0, pen down, stack empty.
`default_nettype none

module turtle_command_engine_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // command words
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [tce_pkg::KIND_W-1:0]          req_kind,
   input  wire logic signed [tce_pkg::AMT_W-1:0]    req_amount,
   // result words
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [tce_pkg::POS_W-1:0]         rsp_start_x,
   output logic signed [tce_pkg::POS_W-1:0]         rsp_start_y,
   output logic signed [tce_pkg::POS_W-1:0]         rsp_end_x,
   output logic signed [tce_pkg::POS_W-1:0]         rsp_end_y,
   output logic [tce_pkg::HEAD_W-1:0]               rsp_heading,
   output logic                                     rsp_is_move,
   output logic                                     rsp_drawn,
   output logic                                     rsp_stack_error,
   output logic                                     rsp_saturated
);

   // Controller tells the datapath what to do each cycle; the datapath
   // reports the class of the word it holds.
   tce_pkg::tce_cmd_type  cmd;
   tce_pkg::tce_stat_type stat;

   tce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: turtle state, save stack, series unit and result register
   tce_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_kind        (req_kind),
      .req_amount      (req_amount),
      .rsp_start_x     (rsp_start_x),
      .rsp_start_y     (rsp_start_y),
      .rsp_end_x       (rsp_end_x),
      .rsp_end_y       (rsp_end_y),
      .rsp_heading     (rsp_heading),
      .rsp_is_move     (rsp_is_move),
      .rsp_drawn       (rsp_drawn),
      .rsp_stack_error (rsp_stack_error),
      .rsp_saturated   (rsp_saturated)
   );

   // Hold off further words once one has been taken
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("word accepted while busy");

   // Heading always wrapped into one full turn
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_heading < tce_pkg::FULL_TURN))
      else $error("heading out of range");

   // Only moves draw or clamp
   a_non_move_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_move) |-> (!rsp_drawn && !rsp_saturated))
      else $error("draw or clamp flag on a non-move");

   // Moves never touch the stack
   a_move_stack: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_move) |-> !rsp_stack_error)
      else $error("stack error on a move");

endmodule

`default_nettype wire

@@ rtl/core/tce_ctrl.sv @@
// Sequencing state machine of the turtle command engine.
// Depends on tce_pkg; drives the datapath tce_dp through tce_cmd_type.
`default_nettype none

module tce_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire tce_pkg::tce_stat_type stat,
   output tce_pkg::tce_cmd_type       cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DISP = 4'd1;
   localparam logic [3:0] S_TURN = 4'd2;
   localparam logic [3:0] S_SQ   = 4'd3;
   localparam logic [3:0] S_X2   = 4'd4;
   localparam logic [3:0] S_HA   = 4'd5;
   localparam logic [3:0] S_HB   = 4'd6;
   localparam logic [3:0] S_HC   = 4'd7;
   localparam logic [3:0] S_SF   = 4'd8;
   localparam logic [3:0] S_SG   = 4'd9;
   localparam logic [3:0] S_CF   = 4'd10;
   localparam logic [3:0] S_MX   = 4'd11;
   localparam logic [3:0] S_MY   = 4'd12;
   localparam logic [3:0] S_MZ   = 4'd13;
   localparam logic [3:0] S_DONE = 4'd14;

   logic [3:0]                  state_ff, state_in;
   logic [tce_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op       = tce_pkg::OP_NONE;
      cmd.step     = step_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = tce_pkg::OP_ACCEPT;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            cmd.op = tce_pkg::OP_DISP;
            if (stat.is_move) begin
               state_in = S_SQ;
            end else if (stat.is_turn) begin
               state_in = S_TURN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_TURN: begin
            cmd.op   = tce_pkg::OP_TURN;
            state_in = S_DONE;
         end
         S_SQ: begin
            cmd.op   = tce_pkg::OP_SQ;
            step_in  = '0;
            state_in = S_X2;
         end
         S_X2: begin
            cmd.op   = tce_pkg::OP_X2;
            state_in = S_HA;
         end
         S_HA: begin
            cmd.op   = tce_pkg::OP_HA;
            state_in = S_HB;
         end
         S_HB: begin
            cmd.op   = tce_pkg::OP_HB;
            state_in = S_HC;
         end
         S_HC: begin
            cmd.op  = tce_pkg::OP_HC;
            step_in = step_ff + 1'b1;
            if (step_ff == tce_pkg::SIN_LAST) begin
               state_in = S_SF;
            end else if (step_ff == tce_pkg::COS_LAST) begin
               state_in = S_CF;
            end else begin
               state_in = S_HA;
            end
         end
         S_SF: begin
            cmd.op   = tce_pkg::OP_SF;
            state_in = S_SG;
         end
         S_SG: begin
            cmd.op   = tce_pkg::OP_SG;
            state_in = S_HA;
         end
         S_CF: begin
            cmd.op   = tce_pkg::OP_CF;
            state_in = S_MX;
         end
         S_MX: begin
            cmd.op   = tce_pkg::OP_MX;
            state_in = S_MY;
         end
         S_MY: begin
            cmd.op   = tce_pkg::OP_MY;
            state_in = S_MZ;
         end
         S_MZ: begin
            cmd.op   = tce_pkg::OP_MZ;
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op       = tce_pkg::OP_RSP;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ rtl/core/tce_dp.sv @@
// Datapath of the turtle command engine: turtle state, save stack, shared
// multiplier, series evaluation and result register. Depends on tce_pkg.
`default_nettype none

module tce_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire tce_pkg::tce_cmd_type                cmd,
   output tce_pkg::tce_stat_type                    stat,
   input  wire logic [tce_pkg::KIND_W-1:0]          req_kind,
   input  wire logic signed [tce_pkg::AMT_W-1:0]    req_amount,
   output logic signed [tce_pkg::POS_W-1:0]         rsp_start_x,
   output logic signed [tce_pkg::POS_W-1:0]         rsp_start_y,
   output logic signed [tce_pkg::POS_W-1:0]         rsp_end_x,
   output logic signed [tce_pkg::POS_W-1:0]         rsp_end_y,
   output logic [tce_pkg::HEAD_W-1:0]               rsp_heading,
   output logic                                     rsp_is_move,
   output logic                                     rsp_drawn,
   output logic                                     rsp_stack_error,
   output logic                                     rsp_saturated
);

   localparam int POS_W  = tce_pkg::POS_W;
   localparam int HEAD_W = tce_pkg::HEAD_W;
   localparam int MUL_W  = tce_pkg::MUL_W;
   localparam int PROD_W = tce_pkg::PROD_W;
   localparam int D_W    = tce_pkg::D_W;
   localparam int TRIG_W = tce_pkg::TRIG_W;
   localparam int TMAG_W = tce_pkg::TMAG_W;

   // Item registers
   logic [tce_pkg::KIND_W-1:0]       kind_ff;
   logic signed [tce_pkg::AMT_W-1:0] amt_ff;
   logic signed [POS_W-1:0]          start_x_ff, start_y_ff;
   logic                             err_ff, sat_ff;

   // Turtle state
   logic signed [POS_W-1:0]     pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [HEAD_W-1:0]           head_ff, head_in;
   logic                        pen_ff, pen_in;
   logic [tce_pkg::CNT_W-1:0]   cnt_ff, cnt_in;

   // Save stack
   tce_pkg::tce_entry_type      mem [tce_pkg::STACK_DEPTH];
   tce_pkg::tce_entry_type      rd_ff;
   logic                        wr_en;
   logic [tce_pkg::PTR_W-1:0]   rd_idx;

   // Arithmetic registers
   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [MUL_W-1:0]     mul_a, mul_b;
   logic [30:0]                 x_ff;
   logic [31:0]                 x2_ff, p_ff;
   logic signed [31:0]          t_ff;
   logic signed [MUL_W-1:0]     hh_ff, hh_in;
   logic [1:0]                  quad_ff, quad;
   logic [HEAD_W-1:0]           quad_base;
   logic [tce_pkg::REM_W-1:0]   rem_q;
   logic [TMAG_W-1:0]           sin_ff, cos_ff;
   logic signed [TRIG_W-1:0]    cs, sn;
   logic signed [D_W-1:0]       dx_ff;

   // Series step
   logic [31:0]                 q0;
   logic [7:0]                  k_cur;
   logic [39:0]                 qk, hrem;
   logic [31:0]                 qq;

   // Heading reduction
   logic [8:0]                  tq;
   logic [MUL_W-1:0]            tqf, trem, trem2;

   // Move update
   logic signed [D_W-1:0]       dx_f, dy_f, dy_now;
   logic signed [D_W:0]         sum_x, sum_y;
   logic                        sat_x, sat_y;
   logic signed [POS_W-1:0]     new_x, new_y;

   function automatic logic signed [POS_W-1:0] clamp32(input logic signed [D_W:0] v,
                                                       output logic hit);
      hit = 1'b0;
      if (v > $signed((D_W+1)'({1'b0, {(POS_W-1){1'b1}}}))) begin
         hit = 1'b1;
         return {1'b0, {(POS_W-1){1'b1}}};
      end else if (v < -$signed((D_W+1)'({1'b1, {(POS_W-1){1'b0}}}))) begin
         hit = 1'b1;
         return {1'b1, {(POS_W-1){1'b0}}};
      end
      return v[POS_W-1:0];
   endfunction

   assign stat.is_move = (kind_ff == tce_pkg::KIND_FWD) || (kind_ff == tce_pkg::KIND_BACK);
   assign stat.is_turn = (kind_ff == tce_pkg::KIND_LEFT) || (kind_ff == tce_pkg::KIND_RIGHT);

   // Quadrant and remainder of the heading
   always_comb begin
      if (head_ff >= tce_pkg::THREE_QUARTER_TURN) begin
         quad = 2'd3;
         quad_base = tce_pkg::THREE_QUARTER_TURN;
      end else if (head_ff >= tce_pkg::HALF_TURN) begin
         quad = 2'd2;
         quad_base = tce_pkg::HALF_TURN;
      end else if (head_ff >= tce_pkg::QUARTER_TURN) begin
         quad = 2'd1;
         quad_base = tce_pkg::QUARTER_TURN;
      end else begin
         quad = 2'd0;
         quad_base = '0;
      end
      rem_q = tce_pkg::REM_W'(head_ff - quad_base);
   end

   // Biased turn sum, always non-negative
   always_comb begin
      if (kind_ff == tce_pkg::KIND_LEFT) begin
         hh_in = $signed(MUL_W'(head_ff)) - MUL_W'(amt_ff) + $signed(tce_pkg::TURN_BIAS);
      end else begin
         hh_in = $signed(MUL_W'(head_ff)) + MUL_W'(amt_ff) + $signed(tce_pkg::TURN_BIAS);
      end
   end

   // Trig values by quadrant
   always_comb begin
      case (quad_ff)
         2'd0: begin
            cs = $signed(TRIG_W'(cos_ff));
            sn = $signed(TRIG_W'(sin_ff));
         end
         2'd1: begin
            cs = -$signed(TRIG_W'(sin_ff));
            sn = $signed(TRIG_W'(cos_ff));
         end
         2'd2: begin
            cs = -$signed(TRIG_W'(cos_ff));
            sn = -$signed(TRIG_W'(sin_ff));
         end
         default: begin
            cs = $signed(TRIG_W'(sin_ff));
            sn = -$signed(TRIG_W'(cos_ff));
         end
      endcase
   end

   // Shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         tce_pkg::OP_DISP: begin
            if (stat.is_turn) begin
               mul_a = hh_in;
               mul_b = $signed(MUL_W'(tce_pkg::TURN_RECIP));
            end else begin
               mul_a = $signed(MUL_W'(rem_q));
               mul_b = $signed(MUL_W'(tce_pkg::DEG_TO_RAD));
            end
         end
         tce_pkg::OP_SQ: begin
            mul_a = $signed(MUL_W'(prod_ff[48:18]));
            mul_b = $signed(MUL_W'(prod_ff[48:18]));
         end
         tce_pkg::OP_HA: begin
            mul_a = $signed(MUL_W'(x2_ff));
            mul_b = MUL_W'(t_ff);
         end
         tce_pkg::OP_HB: begin
            mul_a = $signed(MUL_W'(prod_ff[61:30]));
            mul_b = $signed(MUL_W'(tce_pkg::HORNER_RECIP[cmd.step]));
         end
         tce_pkg::OP_SF: begin
            mul_a = $signed(MUL_W'(x_ff));
            mul_b = MUL_W'(t_ff);
         end
         tce_pkg::OP_MX: begin
            mul_a = MUL_W'(amt_ff);
            mul_b = MUL_W'(cs);
         end
         tce_pkg::OP_MY: begin
            mul_a = MUL_W'(amt_ff);
            mul_b = MUL_W'(sn);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Series step: t = 1 - floor(p / k) by reciprocal with one correction
   always_comb begin
      k_cur = tce_pkg::HORNER_K[cmd.step];
      q0    = prod_ff[63:32];
      qk    = 40'(q0) * 40'(k_cur);
      hrem  = 40'(p_ff) - qk;
      qq    = (hrem >= 40'(k_cur)) ? q0 + 32'd1 : q0;
   end

   // Heading reduction modulo a full turn
   always_comb begin
      tq    = prod_ff[63:55];
      tqf   = MUL_W'(tq) * MUL_W'(tce_pkg::FULL_TURN);
      trem  = MUL_W'(hh_ff) - tqf;
      trem2 = (trem >= MUL_W'(tce_pkg::FULL_TURN)) ? trem - MUL_W'(tce_pkg::FULL_TURN) : trem;
   end

   // Position update
   always_comb begin
      dy_now = tce_pkg::scale_round(prod_ff);
      if (kind_ff == tce_pkg::KIND_BACK) begin
         dx_f = -dx_ff;
         dy_f = -dy_now;
      end else begin
         dx_f = dx_ff;
         dy_f = dy_now;
      end
      sum_x = (D_W+1)'(pos_x_ff) + (D_W+1)'(dx_f);
      sum_y = (D_W+1)'(pos_y_ff) + (D_W+1)'(dy_f);
      new_x = clamp32(sum_x, sat_x);
      new_y = clamp32(sum_y, sat_y);
   end

   // Turtle state next values
   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      head_in  = head_ff;
      pen_in   = pen_ff;
      cnt_in   = cnt_ff;
      wr_en    = 1'b0;
      case (cmd.op)
         tce_pkg::OP_DISP: begin
            case (kind_ff)
               tce_pkg::KIND_PEN_UP: pen_in = 1'b0;
               tce_pkg::KIND_PEN_DN: pen_in = 1'b1;
               tce_pkg::KIND_SAVE: begin
                  if (cnt_ff < tce_pkg::CNT_W'(tce_pkg::STACK_DEPTH)) begin
                     wr_en  = 1'b1;
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
               tce_pkg::KIND_RESTORE: begin
                  if (cnt_ff != '0) begin
                     cnt_in   = cnt_ff - 1'b1;
                     pos_x_in = rd_ff.x;
                     pos_y_in = rd_ff.y;
                     head_in  = rd_ff.head;
                     pen_in   = rd_ff.pen;
                  end
               end
               default: begin
                  pen_in = pen_ff;
               end
            endcase
         end
         tce_pkg::OP_TURN: head_in = HEAD_W'(trem2);
         tce_pkg::OP_MZ: begin
            pos_x_in = new_x;
            pos_y_in = new_y;
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         head_ff  <= '0;
         pen_ff   <= 1'b1;
         cnt_ff   <= '0;
      end else begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         head_ff  <= head_in;
         pen_ff   <= pen_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Stack memory: write on save, read the top entry every cycle
   assign rd_idx = tce_pkg::PTR_W'(cnt_ff - 1'b1);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cnt_ff[tce_pkg::PTR_W-1:0]] <= '{x: pos_x_ff, y: pos_y_ff,
                                               head: head_ff, pen: pen_ff};
      end
      rd_ff <= mem[rd_idx];
   end

   // Working registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (cmd.op)
         tce_pkg::OP_ACCEPT: begin
            kind_ff    <= req_kind;
            amt_ff     <= req_amount;
            start_x_ff <= pos_x_ff;
            start_y_ff <= pos_y_ff;
         end
         tce_pkg::OP_DISP: begin
            quad_ff <= quad;
            hh_ff   <= hh_in;
            sat_ff  <= 1'b0;
            err_ff  <= ((kind_ff == tce_pkg::KIND_SAVE) &&
                        (cnt_ff >= tce_pkg::CNT_W'(tce_pkg::STACK_DEPTH))) ||
                       ((kind_ff == tce_pkg::KIND_RESTORE) && (cnt_ff == '0));
         end
         tce_pkg::OP_SQ: x_ff <= prod_ff[48:18];
         tce_pkg::OP_X2: begin
            x2_ff <= prod_ff[61:30];
            t_ff  <= $signed(tce_pkg::Q30_ONE);
         end
         tce_pkg::OP_HB: p_ff <= prod_ff[61:30];
         tce_pkg::OP_HC: t_ff <= $signed(tce_pkg::Q30_ONE - qq);
         tce_pkg::OP_SG: begin
            sin_ff <= tce_pkg::to_trig($signed(prod_ff[61:30]));
            t_ff   <= $signed(tce_pkg::Q30_ONE);
         end
         tce_pkg::OP_CF: cos_ff <= tce_pkg::to_trig(t_ff);
         tce_pkg::OP_MY: dx_ff <= tce_pkg::scale_round(prod_ff);
         tce_pkg::OP_MZ: sat_ff <= sat_x || sat_y;
         default: begin
            kind_ff <= kind_ff;
         end
      endcase
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.op == tce_pkg::OP_RSP) begin
         rsp_start_x     <= start_x_ff;
         rsp_start_y     <= start_y_ff;
         rsp_end_x       <= pos_x_ff;
         rsp_end_y       <= pos_y_ff;
         rsp_heading     <= head_ff;
         rsp_is_move     <= stat.is_move;
         rsp_drawn       <= stat.is_move && pen_ff;
         rsp_stack_error <= err_ff;
         rsp_saturated   <= stat.is_move && sat_ff;
      end
   end

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for turtle_command_engine_core: directed table, then random words.
// Depends on tce_pkg and the core RTL; each result is checked against a model or typed row.
`default_nettype none

module tb_top;

   localparam int POS_W  = tce_pkg::POS_W;
   localparam int HEAD_W = tce_pkg::HEAD_W;
   localparam int KIND_W = tce_pkg::KIND_W;
   localparam int AMT_W  = tce_pkg::AMT_W;
   localparam int TFB    = tce_pkg::TRIG_FRAC_BITS;

   localparam int IDLE_LIMIT = 5000;   // cycles with no word moving on either channel
   localparam int HOLD_CYCLES = 400;   // long receiver hold-off
   localparam int RANDOM_WORDS = 1300;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      logic [POS_W-1:0]  start_x;
      logic [POS_W-1:0]  start_y;
      logic [POS_W-1:0]  end_x;
      logic [POS_W-1:0]  end_y;
      logic [HEAD_W-1:0] heading;
      logic              is_move;
      logic              drawn;
      logic              stack_error;
      logic              saturated;
   } segment_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [AMT_W-1:0]  amount;
      logic [5:0]        reps;
      logic              typed;    // use the typed-in segment instead of the model
      segment_type       want;
   } plan_row_type;

   localparam int PLAN_ROWS = 18;
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      '{tce_pkg::KIND_RESTORE, 32'h0000_0000, 6'd1, 1'b1,
        '{32'd0, 32'd0, 32'd0, 32'd0, 25'd0, 1'b0, 1'b0, 1'b1, 1'b0}},
      '{tce_pkg::KIND_FWD, 32'h000A_0000, 6'd1, 1'b1,
        '{32'd0, 32'd0, 32'h000A_0000, 32'd0, 25'd0, 1'b1, 1'b1, 1'b0, 1'b0}},
      '{tce_pkg::KIND_FWD, 32'h7FFF_FFFF, 6'd1, 1'b1,
        '{32'h000A_0000, 32'd0, 32'h7FFF_FFFF, 32'd0, 25'd0, 1'b1, 1'b1, 1'b0, 1'b1}},
      '{tce_pkg::KIND_PEN_UP,  32'h0000_0000, 6'd1, 1'b0, '0},
      '{tce_pkg::KIND_BACK,    32'h8000_0000, 6'd1, 1'b0, '0},
      '{tce_pkg::KIND_RIGHT,   32'h005A_0000, 6'd1, 1'b0, '0},
      '{tce_pkg::KIND_FWD,     32'h0001_0000, 6'd1, 1'b0, '0},
      '{tce_pkg::KIND_LEFT,    32'h8000_0000, 6'd1, 1'b0, '0},
      '{tce_pkg::KIND_RIGHT,   32'h7FFF_FFFF, 6'd1, 1'b0, '0},
      '{tce_pkg::KIND_PEN_DN,  32'hFFFF_FFFF, 6'd1, 1'b0, '0},
      '{tce_pkg::KIND_RIGHT,   32'h002D_0000, 6'd1, 1'b0, '0},
      '{tce_pkg::KIND_BACK,    32'h0064_0000, 6'd1, 1'b0, '0},
      '{tce_pkg::KIND_FWD,     32'hFFFF_FFFF, 6'd1, 1'b0, '0},
      '{tce_pkg::KIND_SAVE,    32'h0000_0000, 6'd17, 1'b0, '0},  // last one hits a full stack
      '{tce_pkg::KIND_LEFT,    32'h00B4_0000, 6'd1, 1'b0, '0},
      '{tce_pkg::KIND_FWD,     32'h8000_0000, 6'd1, 1'b0, '0},
      '{tce_pkg::KIND_RESTORE, 32'h0000_0000, 6'd17, 1'b0, '0},  // last one finds it empty
      '{tce_pkg::KIND_RIGHT,   32'h0100_0000, 6'd1, 1'b0, '0}
   };

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [KIND_W-1:0]        req_kind;
   logic signed [AMT_W-1:0]  req_amount;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [POS_W-1:0]  rsp_start_x;
   logic signed [POS_W-1:0]  rsp_start_y;
   logic signed [POS_W-1:0]  rsp_end_x;
   logic signed [POS_W-1:0]  rsp_end_y;
   logic [HEAD_W-1:0]        rsp_heading;
   logic                     rsp_is_move;
   logic                     rsp_drawn;
   logic                     rsp_stack_error;
   logic                     rsp_saturated;

   turtle_command_engine_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_kind(req_kind), .req_amount(req_amount),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_start_x(rsp_start_x), .rsp_start_y(rsp_start_y),
      .rsp_end_x(rsp_end_x), .rsp_end_y(rsp_end_y),
      .rsp_heading(rsp_heading), .rsp_is_move(rsp_is_move),
      .rsp_drawn(rsp_drawn), .rsp_stack_error(rsp_stack_error),
      .rsp_saturated(rsp_saturated)
   );

   // Turtle state as the bench sees it
   logic signed [POS_W-1:0] turtle_x, turtle_y;
   logic [HEAD_W-1:0]       turtle_head;
   logic                    turtle_pen;
   logic signed [POS_W-1:0] stack_x [tce_pkg::STACK_DEPTH];
   logic signed [POS_W-1:0] stack_y [tce_pkg::STACK_DEPTH];
   logic [HEAD_W-1:0]       stack_head [tce_pkg::STACK_DEPTH];
   logic                    stack_pen [tce_pkg::STACK_DEPTH];
   int                      stack_used;

   segment_type pending_segments [$];
   int          mismatches;
   bit          hold_rsp;         // ask the receiver for one long hold-off

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Cos and sin of a heading in trig precision, quadrant folded in
   function automatic void heading_trig(input logic [HEAD_W-1:0] h,
                                        output longint cs, output longint sn);
      longint kq [11];
      longint quad, rem, x, x2, t, s, c, one;
      kq = '{110, 72, 42, 20, 6, 132, 90, 56, 30, 12, 2};
      one = 64'sd1 << 30;
      quad = longint'(h) / longint'(tce_pkg::QUARTER_TURN);
      rem = longint'(h) % longint'(tce_pkg::QUARTER_TURN);
      x = (rem * 74961321) >>> 18;
      x2 = (x * x) / one;
      t = one;
      for (int i = 0; i < 5; i++) t = one - ((x2 * t) / one) / kq[i];
      s = (x * t) / one;
      t = one;
      for (int i = 5; i < 11; i++) t = one - ((x2 * t) / one) / kq[i];
      c = t;
      // clamp to [0,1], round half up to the trig fraction
      s = (s < 0) ? 0 : (s > one) ? one : s;
      c = (c < 0) ? 0 : (c > one) ? one : c;
      s = (s + ((64'sd1 << (30 - TFB)) >>> 1)) >>> (30 - TFB);
      c = (c + ((64'sd1 << (30 - TFB)) >>> 1)) >>> (30 - TFB);
      case (quad & 3)
         0: begin cs = c;  sn = s;  end
         1: begin cs = -s; sn = c;  end
         2: begin cs = -c; sn = -s; end
         default: begin cs = s; sn = -c; end
      endcase
   endfunction

   // Distance times trig, back to Q16.16, rounded half away from zero
   function automatic longint scaled_step(input longint amt, input longint tr);
      longint p, mag;
      p = amt * tr;
      mag = (p < 0) ? -p : p;
      mag = (mag + (64'sd1 << (TFB - 1))) >>> TFB;
      return (p < 0) ? -mag : mag;
   endfunction

   function automatic logic signed [POS_W-1:0] clamp_coord(input longint v,
                                                           inout logic hit);
      if (v > 64'sd2147483647) begin hit = 1'b1; return 32'sh7FFF_FFFF; end
      if (v < -64'sd2147483648) begin hit = 1'b1; return 32'sh8000_0000; end
      return v[POS_W-1:0];
   endfunction

   // Advance the turtle by one command word and return the segment it reports
   function automatic segment_type turtle_step(input logic [KIND_W-1:0] kind,
                                               input logic signed [AMT_W-1:0] amount);
      segment_type seg;
      longint      cs, sn, dx, dy, h;
      logic        sat;
      seg = '0;
      sat = 1'b0;
      seg.start_x = turtle_x;
      seg.start_y = turtle_y;
      case (kind)
         tce_pkg::KIND_FWD, tce_pkg::KIND_BACK: begin
            heading_trig(turtle_head, cs, sn);
            dx = scaled_step(longint'(amount), cs);
            dy = scaled_step(longint'(amount), sn);
            if (kind == tce_pkg::KIND_BACK) begin dx = -dx; dy = -dy; end
            turtle_x = clamp_coord(longint'(turtle_x) + dx, sat);
            turtle_y = clamp_coord(longint'(turtle_y) + dy, sat);
            seg.is_move = 1'b1;
            seg.drawn = turtle_pen;
         end
         tce_pkg::KIND_LEFT, tce_pkg::KIND_RIGHT: begin
            h = (kind == tce_pkg::KIND_LEFT) ? longint'(turtle_head) - longint'(amount)
                                             : longint'(turtle_head) + longint'(amount);
            h = h % longint'(tce_pkg::FULL_TURN);
            if (h < 0) h += longint'(tce_pkg::FULL_TURN);
            turtle_head = h[HEAD_W-1:0];
         end
         tce_pkg::KIND_PEN_UP: turtle_pen = 1'b0;
         tce_pkg::KIND_PEN_DN: turtle_pen = 1'b1;
         tce_pkg::KIND_SAVE: begin
            if (stack_used >= tce_pkg::STACK_DEPTH) begin
               seg.stack_error = 1'b1;
            end else begin
               stack_x[stack_used] = turtle_x;
               stack_y[stack_used] = turtle_y;
               stack_head[stack_used] = turtle_head;
               stack_pen[stack_used] = turtle_pen;
               stack_used++;
            end
         end
         default: begin
            if (stack_used == 0) begin
               seg.stack_error = 1'b1;
            end else begin
               stack_used--;
               turtle_x = stack_x[stack_used];
               turtle_y = stack_y[stack_used];
               turtle_head = stack_head[stack_used];
               turtle_pen = stack_pen[stack_used];
            end
         end
      endcase
      seg.end_x = turtle_x;
      seg.end_y = turtle_y;
      seg.heading = turtle_head;
      seg.saturated = sat;
      return seg;
   endfunction

   // Offer one command word after a gap and hold it until taken.
   // Valid stays high across back-to-back words; drop it only when a gap follows.
   task automatic send_command(input logic [KIND_W-1:0] kind,
                               input logic [AMT_W-1:0] amount, input bit typed,
                               input segment_type want);
      int          gap;
      segment_type seg;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_amount <= amount;
      do @(posedge clock); while (req_stall);
      seg = turtle_step(kind, amount);
      pending_segments.insert(pending_segments.size(), typed ? want : seg);
   endtask

   // Random word: moves and turns dominate, the stack is kept busy both ways
   task automatic send_random();
      int                r;
      logic [KIND_W-1:0] kind;
      logic [AMT_W-1:0]  amount;
      r = $urandom_range(0, 99);
      if (r < 40) kind = r[0] ? tce_pkg::KIND_FWD : tce_pkg::KIND_BACK;
      else if (r < 65) kind = r[0] ? tce_pkg::KIND_LEFT : tce_pkg::KIND_RIGHT;
      else if (r < 75) kind = r[0] ? tce_pkg::KIND_PEN_UP : tce_pkg::KIND_PEN_DN;
      else if (r < 88) kind = tce_pkg::KIND_SAVE;
      else kind = tce_pkg::KIND_RESTORE;
      if ($urandom_range(0, 7) == 0) amount = $urandom;
      else if (kind == tce_pkg::KIND_LEFT || kind == tce_pkg::KIND_RIGHT)
         amount = $urandom_range(0, 32'h0200_0000);
      else amount = $urandom_range(0, 32'h00FF_FFFF);
      if ($urandom_range(0, 1) == 1) amount = -amount;
      send_command(kind, amount, 1'b0, '0);
   endtask

   // Stimulus: reset, directed table, then random words with one hold-off and one drain
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = tce_pkg::KIND_FWD;
      req_amount = '0;
      hold_rsp = 1'b0;
      mismatches = 0;
      turtle_x = '0;
      turtle_y = '0;
      turtle_head = '0;
      turtle_pen = 1'b1;
      stack_used = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (PLAN[i])
         for (int n = 0; n < PLAN[i].reps; n++)
            send_command(PLAN[i].kind, PLAN[i].amount, PLAN[i].typed, PLAN[i].want);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == 400) hold_rsp <= 1'b1;
         if (n == 800) begin
            // Pause the sender until every result is home
            req_valid <= 1'b0;
            while (pending_segments.size() != 0) @(posedge clock);
         end
         send_random();
      end
      req_valid <= 1'b0;

      while (pending_segments.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Receiver: check each result word, then choose the next stall
   int stall_left;
   int hold_left;
   initial begin
      rsp_stall = 1'b0;
      stall_left = 0;
      hold_left = 0;
   end

   always @(posedge clock) begin
      segment_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_start_x, rsp_start_y, rsp_end_x, rsp_end_y, rsp_heading,
                 rsp_is_move, rsp_drawn, rsp_stack_error, rsp_saturated};
         if (pending_segments.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %p", got);
         end else begin
            want = pending_segments.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected %p, got %p", want, got);
            end
         end
      end
      // Hold off for a long stretch once, otherwise stall in random bursts
      if (hold_rsp && hold_left == 0) begin
         hold_left = HOLD_CYCLES;
         hold_rsp <= 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
         rsp_stall <= (stall_left > 0);
      end
   end

   // Watchdog: give up when nothing moves on either channel for too long
   int idle_cycles;
   initial idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

endmodule

`default_nettype wire
